[hdl/tgf_pkg.sv]
`timescale 1ns / 1ps

package tgf_pkg;

  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned OCC_BITS  = 5;
  localparam int unsigned THR_BITS  = 4;

  localparam logic [THR_BITS-1:0] THR_RESET = 4'd3;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_RD_A = 2'd1,
    OP_RD_B = 2'd2,
    OP_RD_C = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_PARKED = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SERVE_RD,
    S_SERVE
  } state_e;

  typedef struct packed {
    logic [1:0]           requester;
    logic [DATA_BITS-1:0] data;
    logic [1:0]           status;
    logic                 removed;
    logic [OCC_BITS-1:0]  occupancy;
    logic                 last;
  } res_t;

endpackage

[hdl/three_reader_gated_fifo.sv]
`timescale 1ns / 1ps

// channel   valid        stall        payload
// ------    -----------  -----------  ------------------------------------------------
// in        in_valid_i   in_stall_o   operation_i, value_i
// out       out_valid_o  out_stall_i  requester_o, data_o, status_o, removed_o,
//                                     occupancy_o, last_o
// cfg       cfg_we_i     -            cfg_wdata_i (read threshold)
//
// A request passes through S_EXEC, then S_SERVE_RD and S_SERVE for each reader grant it
// triggers; each grant waits on the registered read of the head word from the entry memory.
// One request is handled at a time; in_stall_o stays high until its last result is loaded.
// Reset clears pointers, count, seen and parked flags and sets the threshold to 3; the
// entry memory is not cleared, so there is no clearing pass.
// out_stall_i holds the sequencer at each result until the output register frees.
module three_reader_gated_fifo #(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         requester_o,
  output logic signed [31:0] data_o,
  output logic [1:0]         status_o,
  output logic               removed_o,
  output logic [4:0]         occupancy_o,
  output logic               last_o
);

  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);

  logic                 out_free;
  logic                 res_valid;
  tgf_pkg::res_t        res;
  logic                 mem_we;
  logic [PTR_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [PTR_W-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  tgf_mem #(
    .DEPTH     (BUFFER_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tgf_ctrl #(
    .DEPTH     (BUFFER_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tgf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .requester_o (requester_o),
    .data_o      (data_o),
    .status_o    (status_o),
    .removed_o   (removed_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o)
  );

endmodule

[hdl/tgf_mem.sv]
`timescale 1ns / 1ps

module tgf_mem #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WORD_BITS-1:0]     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WORD_BITS-1:0]     rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tgf_out_reg.sv]
`timescale 1ns / 1ps

module tgf_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  tgf_pkg::res_t            res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               requester_o,
  output logic signed [31:0]       data_o,
  output logic [1:0]               status_o,
  output logic                     removed_o,
  output logic [4:0]               occupancy_o,
  output logic                     last_o
);

  logic          valid_q;
  logic          valid_d;
  tgf_pkg::res_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign requester_o = res_q.requester;
  assign data_o      = res_q.data;
  assign status_o    = res_q.status;
  assign removed_o   = res_q.removed;
  assign occupancy_o = res_q.occupancy;
  assign last_o      = res_q.last;

endmodule

[hdl/tgf_ctrl.sv]
`timescale 1ns / 1ps

module tgf_ctrl #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [3:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [31:0]       value_i,
  input  logic                     out_free_i,
  output logic                     res_valid_o,
  output tgf_pkg::res_t            res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [WORD_BITS-1:0]     mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [WORD_BITS-1:0]     mem_rdata_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  function automatic logic [2:0] rdr_mask(tgf_pkg::op_e r);
    logic [2:0] m;
    case (r)
      tgf_pkg::OP_RD_A: m = 3'b001;
      tgf_pkg::OP_RD_B: m = 3'b010;
      tgf_pkg::OP_RD_C: m = 3'b100;
      default:          m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  tgf_pkg::state_e state_q, state_d;
  tgf_pkg::op_e    op_q, op_d;
  tgf_pkg::op_e    cur_q, cur_d;
  logic [31:0]     value_q, value_d;
  logic [3:0]      thr_q;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            seen_a_q, seen_a_d, seen_b_q, seen_b_d;
  logic [2:0]      parked_q, parked_d;

  logic            ok_now;
  logic            ok_pop;
  logic            put_full;
  logic            put_hit;
  tgf_pkg::op_e    put_wake;
  tgf_pkg::op_e    exec_next;
  logic            rd_dup;
  logic            rd_ok;
  logic            srv_pop;
  tgf_pkg::op_e    srv_next;
  logic            srv_a, srv_b;
  logic [CNT_W-1:0] srv_cnt;
  logic [63:0]     wdata_ext;
  logic [63:0]     rdata_ext;

  assign ok_now   = 16'(cnt_q) > 16'(thr_q);
  assign ok_pop   = 16'(cnt_q) > (16'(thr_q) + 16'd1);
  assign put_full = cnt_q == CNT_FULL;
  assign put_hit  = 16'(cnt_q) == 16'(thr_q);
  assign rd_dup   = (parked_q & rdr_mask(op_q)) != 3'b000;
  assign wdata_ext = {32'b0, value_q};
  assign rdata_ext = 64'(mem_rdata_i);

  always_comb begin
    rd_ok = 1'b0;
    case (op_q)
      tgf_pkg::OP_RD_A: rd_ok = ok_now && !seen_a_q;
      tgf_pkg::OP_RD_B: rd_ok = ok_now && !seen_b_q;
      tgf_pkg::OP_RD_C: rd_ok = ok_now && !seen_a_q && !seen_b_q;
      default:          rd_ok = 1'b0;
    endcase
  end

  always_comb begin
    put_wake = tgf_pkg::OP_PUT;
    if (put_hit) begin
      if (parked_q[0] && !seen_a_q) begin
        put_wake = tgf_pkg::OP_RD_A;
      end else if (parked_q[1] && !seen_b_q) begin
        put_wake = tgf_pkg::OP_RD_B;
      end else if (parked_q[2] && !seen_a_q && !seen_b_q) begin
        put_wake = tgf_pkg::OP_RD_C;
      end
    end
  end

  always_comb begin
    exec_next = tgf_pkg::OP_PUT;
    if (op_q == tgf_pkg::OP_PUT) begin
      if (!put_full) begin
        exec_next = put_wake;
      end
    end else if (!rd_dup && rd_ok) begin
      exec_next = op_q;
    end
  end

  always_comb begin
    srv_pop  = 1'b0;
    srv_next = tgf_pkg::OP_PUT;
    srv_a    = seen_a_q;
    srv_b    = seen_b_q;
    case (cur_q)
      tgf_pkg::OP_RD_C: begin
        srv_pop = 1'b1;
      end
      tgf_pkg::OP_RD_A: begin
        if (seen_b_q) begin
          srv_pop = 1'b1;
          srv_a   = 1'b0;
          srv_b   = 1'b0;
          if (ok_pop && parked_q[1]) begin
            srv_next = tgf_pkg::OP_RD_B;
          end else if (ok_pop && parked_q[2]) begin
            srv_next = tgf_pkg::OP_RD_C;
          end
        end else begin
          srv_a = 1'b1;
          if (ok_now && parked_q[1]) begin
            srv_next = tgf_pkg::OP_RD_B;
          end
        end
      end
      tgf_pkg::OP_RD_B: begin
        if (seen_a_q) begin
          srv_pop = 1'b1;
          srv_a   = 1'b0;
          srv_b   = 1'b0;
          if (ok_pop && parked_q[0]) begin
            srv_next = tgf_pkg::OP_RD_A;
          end else if (ok_pop && parked_q[2]) begin
            srv_next = tgf_pkg::OP_RD_C;
          end
        end else begin
          srv_b = 1'b1;
          if (ok_now && parked_q[0]) begin
            srv_next = tgf_pkg::OP_RD_A;
          end
        end
      end
      default: begin
        srv_pop = 1'b0;
      end
    endcase
    srv_cnt = srv_pop ? cnt_q - CNT_W'(1) : cnt_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tgf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tgf_pkg::S_EXEC;
        end
      end
      tgf_pkg::S_EXEC: begin
        if (out_free_i) begin
          state_d = (exec_next != tgf_pkg::OP_PUT) ? tgf_pkg::S_SERVE_RD : tgf_pkg::S_IDLE;
        end
      end
      tgf_pkg::S_SERVE_RD: begin
        state_d = tgf_pkg::S_SERVE;
      end
      tgf_pkg::S_SERVE: begin
        if (out_free_i) begin
          state_d = (srv_next != tgf_pkg::OP_PUT) ? tgf_pkg::S_SERVE_RD : tgf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tgf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o  = state_q != tgf_pkg::S_IDLE;
    op_d        = op_q;
    value_d     = value_q;
    cur_d       = cur_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    seen_a_d    = seen_a_q;
    seen_b_d    = seen_b_q;
    parked_d    = parked_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = wdata_ext[WORD_BITS-1:0];
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    case (state_q)
      tgf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = tgf_pkg::op_e'(operation_i);
          value_d = value_i;
        end
      end
      tgf_pkg::S_EXEC: begin
        if (out_free_i) begin
          res_valid_o     = 1'b1;
          res_o.requester = op_q;
          res_o.occupancy = 5'(cnt_q);
          res_o.last      = exec_next == tgf_pkg::OP_PUT;
          cur_d           = exec_next;
          if (op_q == tgf_pkg::OP_PUT) begin
            if (put_full) begin
              res_o.status = tgf_pkg::ST_FULL;
            end else begin
              mem_we_o        = 1'b1;
              tail_d          = ptr_inc(tail_q);
              cnt_d           = cnt_q + CNT_W'(1);
              res_o.status    = tgf_pkg::ST_DONE;
              res_o.occupancy = 5'(cnt_d);
            end
          end else if (rd_dup) begin
            res_o.status = tgf_pkg::ST_DUP;
          end else if (!rd_ok) begin
            parked_d     = parked_q | rdr_mask(op_q);
            res_o.status = tgf_pkg::ST_PARKED;
          end else begin
            res_valid_o = 1'b0;
          end
        end
      end
      tgf_pkg::S_SERVE_RD: begin
        mem_re_o = 1'b1;
        parked_d = parked_q & ~rdr_mask(cur_q);
      end
      tgf_pkg::S_SERVE: begin
        if (out_free_i) begin
          res_valid_o     = 1'b1;
          res_o.requester = cur_q;
          res_o.data      = rdata_ext[31:0];
          res_o.status    = tgf_pkg::ST_DONE;
          res_o.removed   = srv_pop;
          res_o.occupancy = 5'(srv_cnt);
          res_o.last      = srv_next == tgf_pkg::OP_PUT;
          seen_a_d        = srv_a;
          seen_b_d        = srv_b;
          cnt_d           = srv_cnt;
          head_d          = srv_pop ? ptr_inc(head_q) : head_q;
          cur_d           = srv_next;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tgf_pkg::S_IDLE;
      cur_q    <= tgf_pkg::OP_PUT;
      thr_q    <= tgf_pkg::THR_RESET;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      seen_a_q <= 1'b0;
      seen_b_q <= 1'b0;
      parked_q <= 3'b000;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      seen_a_q <= seen_a_d;
      seen_b_q <= seen_b_d;
      parked_q <= parked_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    value_q <= value_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    16'(cnt_q) <= 16'(DEPTH))
    else $error("entry count above depth");

  a_seen_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(seen_a_q && seen_b_q))
    else $error("head marked seen by both A and B");

  a_serve_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgf_pkg::S_SERVE) |-> (ok_now && (parked_q & rdr_mask(cur_q)) == 3'b000))
    else $error("grant with too few entries or reader still parked");

  a_ptr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_FULL) |-> (head_q == tail_q))
    else $error("pointers disagree with entry count");

  a_rd_then_serve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgf_pkg::S_SERVE_RD) |=> (state_q == tgf_pkg::S_SERVE && $stable(head_q)))
    else $error("head moved between memory read and grant");

endmodule
